// ===== rtl/epr_pkg.sv =====
// shared types, constants and rounding helper for the epipolar row builder
package epr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int COEF_WIDTH  = 40;
    localparam int FRAC_BITS   = 20;
    localparam int NUM_COORD   = 4;
    localparam int NUM_COEF    = 9;
    localparam int NUM_ROWS    = 4;

    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int RAD_W  = SQ_W;
    localparam int RSUM_W = RAD_W + 1;
    localparam int CR_W   = 3 * COORD_WIDTH;
    localparam int WIDE_W = 4 * COORD_WIDTH;

    // coordinate slots
    localparam int IDX_U1 = 0;
    localparam int IDX_U2 = 1;
    localparam int IDX_V1 = 2;
    localparam int IDX_V2 = 3;

    // model_mode codes
    localparam logic [1:0] MODE_INVALID     = 2'd0;
    localparam logic [1:0] MODE_SECOND_ONLY = 2'd1;
    localparam logic [1:0] MODE_SHARED      = 2'd2;
    localparam logic [1:0] MODE_SEPARATE    = 2'd3;

    // matrix ids
    localparam logic [1:0] MAT_A = 2'd0;
    localparam logic [1:0] MAT_B = 2'd1;
    localparam logic [1:0] MAT_C = 2'd2;
    localparam logic [1:0] MAT_D = 2'd3;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [COORD_WIDTH-1:0] mag_t;
    typedef logic [SQ_W-1:0]        sq_t;
    typedef logic [RAD_W-1:0]       rad_t;
    typedef logic [RSUM_W-1:0]      rsum_t;
    typedef logic [CR_W-1:0]        cr_t;
    typedef logic [WIDE_W-1:0]      wide_t;
    typedef logic [COEF_WIDTH-1:0]  coef_t;
    typedef coef_t [NUM_COEF-1:0]   row_t;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [NUM_COORD-1:0]       neg;
        mag_t [NUM_COORD-1:0]       mag;
        rad_t                       ru;
        rad_t                       rv;
        row_t                       a_row;
    } front_t;

    typedef struct packed {
        logic                       bad;
        row_t [NUM_ROWS-1:0]        rows;
    } rows_t;

    // magnitude / 2^sh rounded to nearest, ties away from zero, then signed
    function automatic coef_t round_mag(input wide_t mag, input int unsigned sh,
                                        input logic neg);
        logic [WIDE_W:0] sum;
        logic [WIDE_W:0] shifted;
        coef_t           r;
        sum     = {1'b0, mag} + ({{WIDE_W{1'b0}}, 1'b1} << (sh - 1));
        shifted = sum >> sh;
        r       = shifted[COEF_WIDTH-1:0];
        round_mag = neg ? coef_t'(-r) : r;
    endfunction

endpackage

// ===== rtl/epr_front.sv =====
// front pipeline: sign split, squares and cross products, radii and matrix A row
module epr_front (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic [1:0]                                       in_mode,
    input  epr_pkg::coord_t [epr_pkg::NUM_COORD-1:0]         in_coord,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output epr_pkg::front_t                                  out_data
);

    // stage 1
    logic                                     s1_valid_reg;
    logic [1:0]                               s1_mode_reg;
    logic [epr_pkg::NUM_COORD-1:0]            s1_neg_reg;
    epr_pkg::mag_t [epr_pkg::NUM_COORD-1:0]   s1_mag_reg;
    epr_pkg::coord_t [epr_pkg::NUM_COORD-1:0] s1_raw_reg;
    logic [epr_pkg::NUM_COORD-1:0]            s1_neg_next;
    epr_pkg::mag_t [epr_pkg::NUM_COORD-1:0]   s1_mag_next;

    // stage 2
    logic                                     s2_valid_reg;
    logic [1:0]                               s2_mode_reg;
    logic [epr_pkg::NUM_COORD-1:0]            s2_neg_reg;
    epr_pkg::mag_t [epr_pkg::NUM_COORD-1:0]   s2_mag_reg;
    epr_pkg::coord_t [epr_pkg::NUM_COORD-1:0] s2_raw_reg;
    epr_pkg::sq_t [epr_pkg::NUM_COORD-1:0]    s2_sq_reg;
    epr_pkg::sq_t [3:0]                       s2_cross_reg;
    logic [3:0]                               s2_cross_neg_reg;
    epr_pkg::sq_t [epr_pkg::NUM_COORD-1:0]    s2_sq_next;
    epr_pkg::sq_t [3:0]                       s2_cross_next;
    logic [3:0]                               s2_cross_neg_next;

    // stage 3
    logic                                     s3_valid_reg;
    epr_pkg::front_t                          s3_data_reg;
    epr_pkg::front_t                          s3_data_next;

    logic s1_load;
    logic s2_load;
    logic s3_load;

    assign s3_load  = !s3_valid_reg || out_ready;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    always_comb begin
        for (int i = 0; i < epr_pkg::NUM_COORD; i++) begin
            s1_neg_next[i] = in_coord[i][epr_pkg::COORD_WIDTH-1];
            s1_mag_next[i] = s1_neg_next[i] ? epr_pkg::mag_t'(-in_coord[i]) : in_coord[i];
        end
    end

    always_comb begin
        for (int i = 0; i < epr_pkg::NUM_COORD; i++) begin
            s2_sq_next[i] = epr_pkg::sq_t'(s1_mag_reg[i]) * epr_pkg::sq_t'(s1_mag_reg[i]);
        end
        // u1v1, u1v2, u2v1, u2v2
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                s2_cross_next[2*a+b] = epr_pkg::sq_t'(s1_mag_reg[epr_pkg::IDX_U1+a])
                                     * epr_pkg::sq_t'(s1_mag_reg[epr_pkg::IDX_V1+b]);
                s2_cross_neg_next[2*a+b] = s1_neg_reg[epr_pkg::IDX_U1+a]
                                         ^ s1_neg_reg[epr_pkg::IDX_V1+b];
            end
        end
    end

    always_comb begin
        s3_data_next.mode = s2_mode_reg;
        s3_data_next.neg  = s2_neg_reg;
        s3_data_next.mag  = s2_mag_reg;
        s3_data_next.ru   = s2_sq_reg[epr_pkg::IDX_U1] + s2_sq_reg[epr_pkg::IDX_U2];
        s3_data_next.rv   = s2_sq_reg[epr_pkg::IDX_V1] + s2_sq_reg[epr_pkg::IDX_V2];
        s3_data_next.a_row[0] = epr_pkg::round_mag(epr_pkg::wide_t'(s2_cross_reg[0]),
                                    epr_pkg::FRAC_BITS, s2_cross_neg_reg[0]);
        s3_data_next.a_row[1] = epr_pkg::round_mag(epr_pkg::wide_t'(s2_cross_reg[1]),
                                    epr_pkg::FRAC_BITS, s2_cross_neg_reg[1]);
        s3_data_next.a_row[3] = epr_pkg::round_mag(epr_pkg::wide_t'(s2_cross_reg[2]),
                                    epr_pkg::FRAC_BITS, s2_cross_neg_reg[2]);
        s3_data_next.a_row[4] = epr_pkg::round_mag(epr_pkg::wide_t'(s2_cross_reg[3]),
                                    epr_pkg::FRAC_BITS, s2_cross_neg_reg[3]);
        // plain coordinates are just sign extended
        s3_data_next.a_row[2] = epr_pkg::coef_t'(signed'(s2_raw_reg[epr_pkg::IDX_U1]));
        s3_data_next.a_row[5] = epr_pkg::coef_t'(signed'(s2_raw_reg[epr_pkg::IDX_U2]));
        s3_data_next.a_row[6] = epr_pkg::coef_t'(signed'(s2_raw_reg[epr_pkg::IDX_V1]));
        s3_data_next.a_row[7] = epr_pkg::coef_t'(signed'(s2_raw_reg[epr_pkg::IDX_V2]));
        s3_data_next.a_row[8] = epr_pkg::coef_t'(1) << epr_pkg::FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_load) s1_valid_reg <= in_valid;
            if (s2_load) s2_valid_reg <= s1_valid_reg;
            if (s3_load) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_mode_reg <= in_mode;
            s1_neg_reg  <= s1_neg_next;
            s1_mag_reg  <= s1_mag_next;
            s1_raw_reg  <= in_coord;
        end
        if (s2_load) begin
            s2_mode_reg      <= s1_mode_reg;
            s2_neg_reg       <= s1_neg_reg;
            s2_mag_reg       <= s1_mag_reg;
            s2_raw_reg       <= s1_raw_reg;
            s2_sq_reg        <= s2_sq_next;
            s2_cross_reg     <= s2_cross_next;
            s2_cross_neg_reg <= s2_cross_neg_next;
        end
        if (s3_load) begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

// ===== rtl/epr_back.sv =====
// back pipeline: radius products in partial products, rounding, row assembly per mode
module epr_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  epr_pkg::front_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output epr_pkg::rows_t  out_data
);

    localparam int W = epr_pkg::COORD_WIDTH;

    // stage 4: 24x24 partial products
    logic                                   s4_valid_reg;
    epr_pkg::front_t                        s4_front_reg;
    epr_pkg::sq_t [epr_pkg::NUM_COORD-1:0]  s4_cr_lo_reg;
    epr_pkg::sq_t [epr_pkg::NUM_COORD-1:0]  s4_cr_hi_reg;
    epr_pkg::sq_t [3:0]                     s4_rr_reg;
    epr_pkg::sq_t [epr_pkg::NUM_COORD-1:0]  s4_cr_lo_next;
    epr_pkg::sq_t [epr_pkg::NUM_COORD-1:0]  s4_cr_hi_next;
    epr_pkg::sq_t [3:0]                     s4_rr_next;
    epr_pkg::rad_t                          radius;

    // stage 5: full products
    logic                                   s5_valid_reg;
    epr_pkg::front_t                        s5_front_reg;
    epr_pkg::cr_t [epr_pkg::NUM_COORD-1:0]  s5_cr_reg;
    epr_pkg::wide_t                         s5_rr_reg;
    epr_pkg::rsum_t                         s5_rsum_reg;
    epr_pkg::cr_t [epr_pkg::NUM_COORD-1:0]  s5_cr_next;
    epr_pkg::wide_t                         s5_rr_next;

    // stage 6: rounded rows
    logic                                   s6_valid_reg;
    epr_pkg::rows_t                         s6_rows_reg;
    epr_pkg::rows_t                         s6_rows_next;
    epr_pkg::coef_t [epr_pkg::NUM_COORD-1:0] cr_rnd;
    epr_pkg::coef_t                         rr_rnd;
    epr_pkg::coef_t                         rv_rnd;
    epr_pkg::coef_t                         ru_rnd;
    epr_pkg::coef_t                         rsum_rnd;

    logic s4_load;
    logic s5_load;
    logic s6_load;

    assign s6_load  = !s6_valid_reg || out_ready;
    assign s5_load  = !s5_valid_reg || s6_load;
    assign s4_load  = !s4_valid_reg || s5_load;
    assign in_ready = s4_load;

    // u1, u2 go with rv; v1, v2 go with ru
    always_comb begin
        radius = '0;
        for (int k = 0; k < epr_pkg::NUM_COORD; k++) begin
            radius = (k < epr_pkg::IDX_V1) ? in_data.rv : in_data.ru;
            s4_cr_lo_next[k] = epr_pkg::sq_t'(in_data.mag[k])
                             * epr_pkg::sq_t'(radius[W-1:0]);
            s4_cr_hi_next[k] = epr_pkg::sq_t'(in_data.mag[k])
                             * epr_pkg::sq_t'(radius[2*W-1:W]);
        end
        s4_rr_next[0] = epr_pkg::sq_t'(in_data.ru[W-1:0])   * epr_pkg::sq_t'(in_data.rv[W-1:0]);
        s4_rr_next[1] = epr_pkg::sq_t'(in_data.ru[W-1:0])   * epr_pkg::sq_t'(in_data.rv[2*W-1:W]);
        s4_rr_next[2] = epr_pkg::sq_t'(in_data.ru[2*W-1:W]) * epr_pkg::sq_t'(in_data.rv[W-1:0]);
        s4_rr_next[3] = epr_pkg::sq_t'(in_data.ru[2*W-1:W]) * epr_pkg::sq_t'(in_data.rv[2*W-1:W]);
    end

    always_comb begin
        for (int k = 0; k < epr_pkg::NUM_COORD; k++) begin
            s5_cr_next[k] = epr_pkg::cr_t'(s4_cr_lo_reg[k])
                          + (epr_pkg::cr_t'(s4_cr_hi_reg[k]) << W);
        end
        s5_rr_next = epr_pkg::wide_t'(s4_rr_reg[0])
                   + (epr_pkg::wide_t'(s4_rr_reg[1]) << W)
                   + (epr_pkg::wide_t'(s4_rr_reg[2]) << W)
                   + (epr_pkg::wide_t'(s4_rr_reg[3]) << (2 * W));
    end

    always_comb begin
        for (int k = 0; k < epr_pkg::NUM_COORD; k++) begin
            cr_rnd[k] = epr_pkg::round_mag(epr_pkg::wide_t'(s5_cr_reg[k]),
                                           2 * epr_pkg::FRAC_BITS, s5_front_reg.neg[k]);
        end
        rr_rnd   = epr_pkg::round_mag(s5_rr_reg, 3 * epr_pkg::FRAC_BITS, 1'b0);
        rv_rnd   = epr_pkg::round_mag(epr_pkg::wide_t'(s5_front_reg.rv),
                                      epr_pkg::FRAC_BITS, 1'b0);
        ru_rnd   = epr_pkg::round_mag(epr_pkg::wide_t'(s5_front_reg.ru),
                                      epr_pkg::FRAC_BITS, 1'b0);
        rsum_rnd = epr_pkg::round_mag(epr_pkg::wide_t'(s5_rsum_reg),
                                      epr_pkg::FRAC_BITS, 1'b0);

        s6_rows_next = '0;
        case (s5_front_reg.mode)
            epr_pkg::MODE_SECOND_ONLY: begin
                s6_rows_next.rows[epr_pkg::MAT_A]    = s5_front_reg.a_row;
                s6_rows_next.rows[epr_pkg::MAT_B][2] = cr_rnd[epr_pkg::IDX_U1];
                s6_rows_next.rows[epr_pkg::MAT_B][5] = cr_rnd[epr_pkg::IDX_U2];
                s6_rows_next.rows[epr_pkg::MAT_B][8] = rv_rnd;
            end
            epr_pkg::MODE_SHARED: begin
                s6_rows_next.rows[epr_pkg::MAT_A]    = s5_front_reg.a_row;
                s6_rows_next.rows[epr_pkg::MAT_B][2] = cr_rnd[epr_pkg::IDX_U1];
                s6_rows_next.rows[epr_pkg::MAT_B][5] = cr_rnd[epr_pkg::IDX_U2];
                s6_rows_next.rows[epr_pkg::MAT_B][6] = cr_rnd[epr_pkg::IDX_V1];
                s6_rows_next.rows[epr_pkg::MAT_B][7] = cr_rnd[epr_pkg::IDX_V2];
                s6_rows_next.rows[epr_pkg::MAT_B][8] = rsum_rnd;
                s6_rows_next.rows[epr_pkg::MAT_D][8] = rr_rnd;
            end
            epr_pkg::MODE_SEPARATE: begin
                s6_rows_next.rows[epr_pkg::MAT_A]    = s5_front_reg.a_row;
                s6_rows_next.rows[epr_pkg::MAT_B][2] = cr_rnd[epr_pkg::IDX_U1];
                s6_rows_next.rows[epr_pkg::MAT_B][5] = cr_rnd[epr_pkg::IDX_U2];
                s6_rows_next.rows[epr_pkg::MAT_B][8] = rv_rnd;
                s6_rows_next.rows[epr_pkg::MAT_C][6] = cr_rnd[epr_pkg::IDX_V1];
                s6_rows_next.rows[epr_pkg::MAT_C][7] = cr_rnd[epr_pkg::IDX_V2];
                s6_rows_next.rows[epr_pkg::MAT_C][8] = ru_rnd;
                s6_rows_next.rows[epr_pkg::MAT_D][8] = rr_rnd;
            end
            default: begin
                s6_rows_next.bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else begin
            if (s4_load) s4_valid_reg <= in_valid;
            if (s5_load) s5_valid_reg <= s4_valid_reg;
            if (s6_load) s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_load) begin
            s4_front_reg <= in_data;
            s4_cr_lo_reg <= s4_cr_lo_next;
            s4_cr_hi_reg <= s4_cr_hi_next;
            s4_rr_reg    <= s4_rr_next;
        end
        if (s5_load) begin
            s5_front_reg <= s4_front_reg;
            s5_cr_reg    <= s5_cr_next;
            s5_rr_reg    <= s5_rr_next;
            s5_rsum_reg  <= {1'b0, s4_front_reg.ru} + {1'b0, s4_front_reg.rv};
        end
        if (s6_load) begin
            s6_rows_reg <= s6_rows_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_data  = s6_rows_reg;

endmodule

// ===== rtl/epr_row_serializer.sv =====
// output register: keeps a point's rows, one word out per cycle while out_ready
module epr_row_serializer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  epr_pkg::rows_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_matrix_id,
    output epr_pkg::row_t  out_row,
    output logic           out_last,
    output logic           out_bad
);

    logic           valid_reg;
    logic [1:0]     idx_reg;
    epr_pkg::rows_t rows_reg;
    logic           last;

    // invalid mode gives a single row
    assign last     = rows_reg.bad || (idx_reg == epr_pkg::MAT_D);
    assign in_ready = !valid_reg || (out_ready && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= epr_pkg::MAT_A;
        end else if (in_ready) begin
            valid_reg <= in_valid;
            idx_reg   <= epr_pkg::MAT_A;
        end else if (out_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rows_reg <= in_data;
        end
    end

    assign out_valid     = valid_reg;
    assign out_matrix_id = idx_reg;
    assign out_row       = rows_reg.rows[idx_reg];
    assign out_last      = last;
    assign out_bad       = rows_reg.bad;

endmodule

// ===== rtl/distortion_epipolar_row_builder_unit.sv =====
// top level of the division-model epipolar coefficient row builder
//
// each accepted correspondence (first_x, first_y, second_x, second_y, signed q3.20)
// produces four result words, matrices a, b, c, d in that order, each carrying nine
// signed coefficients with 20 fraction bits, rounded to nearest with ties away from
// zero; rows a mode leaves undefined come out as zeros, and last_of_point marks
// matrix d. with model_mode 0 a single all-zero word with matrix_id 0, last_of_point
// and bad_mode set is produced instead. the datapath is a seven-register pipeline
// (three front stages for squares, cross products and radii, three back stages for
// the radius partial products, their sums and the rounding, then the output
// register). a new point can enter every cycle while stages are free; in steady
// state the single result port sets the pace, as each point leaves as four words
// (one word in the invalid mode). model_mode is captured with each point on entry,
// resets to 1, and should only be written while the block is idle.
module distortion_epipolar_row_builder_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_wr_data,

    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [epr_pkg::COORD_WIDTH-1:0]      s_first_x,
    input  logic [epr_pkg::COORD_WIDTH-1:0]      s_first_y,
    input  logic [epr_pkg::COORD_WIDTH-1:0]      s_second_x,
    input  logic [epr_pkg::COORD_WIDTH-1:0]      s_second_y,

    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_matrix_id,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_0,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_1,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_2,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_3,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_4,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_5,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_6,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_7,
    output logic [epr_pkg::COEF_WIDTH-1:0]       m_coef_8,
    output logic                                 m_last_of_point,
    output logic                                 m_bad_mode
);

    // mode register (invalid, second-only, shared or separate distortion); codes are in epr_pkg
    logic [1:0]                                 mode_reg;

    epr_pkg::coord_t [epr_pkg::NUM_COORD-1:0]   coords;

    // front to back
    logic                                       front_valid;
    logic                                       front_ready;
    epr_pkg::front_t                            front_data;

    // back to output register
    logic                                       back_valid;
    logic                                       back_ready;
    epr_pkg::rows_t                             back_data;

    epr_pkg::row_t                              out_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= epr_pkg::MODE_SECOND_ONLY;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // coordinate slots: u1, u2, v1, v2
    assign coords[epr_pkg::IDX_U1] = s_first_x;
    assign coords[epr_pkg::IDX_U2] = s_first_y;
    assign coords[epr_pkg::IDX_V1] = s_second_x;
    assign coords[epr_pkg::IDX_V2] = s_second_y;

    // squares, cross products, radii, matrix a
    epr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_mode   (mode_reg),
        .in_coord  (coords),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // radius products, rounding, rows b, c, d per mode
    epr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_data)
    );

    // output register, one row per word
    epr_row_serializer u_ser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (back_valid),
        .in_ready      (back_ready),
        .in_data       (back_data),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_matrix_id (m_matrix_id),
        .out_row       (out_row),
        .out_last      (m_last_of_point),
        .out_bad       (m_bad_mode)
    );

    assign m_coef_0 = out_row[0];
    assign m_coef_1 = out_row[1];
    assign m_coef_2 = out_row[2];
    assign m_coef_3 = out_row[3];
    assign m_coef_4 = out_row[4];
    assign m_coef_5 = out_row[5];
    assign m_coef_6 = out_row[6];
    assign m_coef_7 = out_row[7];
    assign m_coef_8 = out_row[8];

    // an invalid-mode word is always the only word of its point
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_mode |-> m_last_of_point && m_matrix_id == epr_pkg::MAT_A)
        else $error("bad-mode word not a single last word");

    // valid modes end on matrix d
    a_last_is_d: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_point && !m_bad_mode |-> m_matrix_id == epr_pkg::MAT_D)
        else $error("last word of a point is not matrix d");

    // rows of one point come out in order with no gap in ids
    a_id_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_point |=>
            m_valid && m_matrix_id == 2'($past(m_matrix_id) + 2'd1))
        else $error("matrix id did not advance by one");

    // a mode-0 word is all zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_mode |-> out_row == '0)
        else $error("bad-mode word carries coefficients");

endmodule
